FILE: design/glpr_pkg.sv
// Shared constants, codes and types for the GIF line palette renderer.
package glpr_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int PAL_AW       = $clog2(PALETTE_SIZE);
  localparam int MAX_COORD    = 1024;
  localparam int OUTQ_DEPTH   = 8;
  localparam int OUTQ_AW      = $clog2(OUTQ_DEPTH);

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 11;

  typedef enum logic [CFG_IW-1:0] {
    REG_DISP_COLS         = 3'd0,
    REG_DISP_ROWS         = 3'd1,
    REG_FRAME_X           = 3'd2,
    REG_FRAME_Y           = 3'd3,
    REG_FRAME_WIDTH       = 3'd4,
    REG_MODE              = 3'd5,
    REG_TRANSPARENT_INDEX = 3'd6,
    REG_BACKGROUND_INDEX  = 3'd7
  } cfg_reg_t;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXEL   = 1'b1;

  localparam logic [1:0] MODE_OPAQUE  = 2'd0;
  localparam logic [1:0] MODE_SKIP    = 2'd1;
  localparam logic [1:0] MODE_RESTORE = 2'd2;

  localparam logic [10:0] DISP_COLS_RESET = 11'd320;
  localparam logic [10:0] DISP_ROWS_RESET = 11'd240;
  localparam logic [10:0] COLUMN_MAX      = 11'h7FF;

  typedef struct packed {
    logic [15:0] rgb;
    logic [9:0]  x;
    logic [9:0]  y;
    logic        span_start;
    logic        span_end;
  } out_t;

endpackage

FILE: design/gif_line_palette_render_core.sv
// Top level of the GIF line palette renderer: palette RAM, span tracking and output queue.

// The renderer accepts one request per clock, palette writes and pixels alike, and
// keeps doing so while results wait at the output. A palette write stores a word in
// a 256-entry synchronous RAM; a pixel is clipped against the display and the frame
// width, has its transparent index skipped or replaced according to the mode, and
// reads the RAM in the cycle it is accepted. In the next cycle the word arrives,
// is byte-swapped and meets the one-pixel hold that decides span_start and span_end;
// a pixel can release up to two results (the held pixel and, at line end, itself).
// Results pass through an eight-entry queue: they are written there at the edge after
// the pixel is accepted, and with the output not stalled the first of them can be
// taken from the queue head. The input is
// stalled only when that queue could not absorb the two results of both the pixel
// in flight and a new one, which happens only under a stalled or slow output.
// A palette write takes effect for a pixel accepted in the very next cycle, since
// the RAM is written before that pixel reads it. Configuration writes are taken at
// any edge with cfg_write high and should only be made while the block is idle.
module gif_line_palette_render_core (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [7:0]                     palette_slot,
  input  logic [15:0]                    palette_color,
  input  logic [7:0]                     pixel_index,
  input  logic [9:0]                     line_number,
  input  logic                           line_end,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    pixel_rgb,
  output logic [9:0]                     screen_x,
  output logic [9:0]                     screen_y,
  output logic                           span_start,
  output logic                           span_end,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [glpr_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [glpr_pkg::CFG_DW-1:0]    cfg_data
);

  import glpr_pkg::*;

  // Configuration registers.
  logic [10:0] disp_cols;
  logic [10:0] disp_rows;
  logic [9:0]  frame_x;
  logic [9:0]  frame_y;
  logic [10:0] frame_width;
  logic [1:0]  mode;
  logic [7:0]  transparent_index;
  logic [7:0]  background_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_cols         <= DISP_COLS_RESET;
      disp_rows         <= DISP_ROWS_RESET;
      frame_x           <= '0;
      frame_y           <= '0;
      frame_width       <= '0;
      mode              <= MODE_OPAQUE;
      transparent_index <= '0;
      background_index  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DISP_COLS:         disp_cols         <= cfg_data;
        REG_DISP_ROWS:         disp_rows         <= cfg_data;
        REG_FRAME_X:           frame_x           <= cfg_data[9:0];
        REG_FRAME_Y:           frame_y           <= cfg_data[9:0];
        REG_FRAME_WIDTH:       frame_width       <= cfg_data;
        REG_MODE:              mode              <= cfg_data[1:0];
        REG_TRANSPARENT_INDEX: transparent_index <= cfg_data[7:0];
        REG_BACKGROUND_INDEX:  background_index  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: clipping, colour key and the palette RAM access.
  // ---------------------------------------------------------------------------
  logic        in_accept;
  logic        is_pixel;
  logic [10:0] column_count;
  logic [10:0] dw;
  logic [10:0] dh;
  logic [11:0] right_edge;
  logic [10:0] line_w;
  logic [10:0] y_full;
  logic        visible;
  logic        key_match;
  logic        transparent;
  logic [7:0]  lookup_index;
  logic [9:0]  pix_x;

  assign in_accept = in_valid && !in_stall;
  assign is_pixel  = (command == CMD_PIXEL);

  always_comb begin
    dw = (disp_cols > 11'(MAX_COORD)) ? 11'(MAX_COORD) : disp_cols;
    dh = (disp_rows > 11'(MAX_COORD)) ? 11'(MAX_COORD) : disp_rows;
    // The frame line is cut at the right edge of the display.
    right_edge = {1'b0, frame_width} + {2'b00, frame_x};
    if (right_edge > {1'b0, dw}) begin
      line_w = dw - {1'b0, frame_x};
    end else begin
      line_w = frame_width;
    end
    y_full  = {1'b0, frame_y} + {1'b0, line_number};
    visible = ({1'b0, frame_x} < dw) && (line_w != 11'd0) && (y_full < dh)
              && (column_count < line_w);
    pix_x   = 10'({1'b0, frame_x} + column_count);

    key_match    = (pixel_index == transparent_index);
    transparent  = (mode == MODE_SKIP) && key_match;
    lookup_index = ((mode == MODE_RESTORE) && key_match) ? background_index : pixel_index;
  end

  // Column within the line; returns to zero on line end, else counts up and saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
    end else if (in_accept && is_pixel) begin
      if (line_end) begin
        column_count <= '0;
      end else if (column_count != COLUMN_MAX) begin
        column_count <= column_count + 11'd1;
      end
    end
  end

  // Palette RAM: one write or one read per cycle, read data registered.
  logic [15:0] pal_mem [PALETTE_SIZE];
  logic [15:0] pal_q;

  always_ff @(posedge clk) begin
    if (in_accept && !is_pixel && ({1'b0, palette_slot} < 9'(PALETTE_SIZE))) begin
      pal_mem[palette_slot[PAL_AW-1:0]] <= palette_color;
    end
    if (in_accept && is_pixel) begin
      pal_q <= pal_mem[lookup_index[PAL_AW-1:0]];
    end
  end

  // Pipeline register in step with the RAM read.
  logic       s1_valid;
  logic       s1_visible;
  logic       s1_transparent;
  logic       s1_index_ok;
  logic       s1_last;
  logic [9:0] s1_x;
  logic [9:0] s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept && is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && is_pixel) begin
      s1_visible     <= visible;
      s1_transparent <= transparent;
      s1_index_ok    <= ({1'b0, lookup_index} < 9'(PALETTE_SIZE));
      s1_last        <= line_end;
      s1_x           <= pix_x;
      s1_y           <= y_full[9:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Span stage: the one-pixel hold decides the run flags.
  // ---------------------------------------------------------------------------
  logic        held_valid;
  logic [15:0] held_rgb;
  logic [9:0]  held_x;
  logic [9:0]  held_y;
  logic        held_first;

  logic        held_valid_next;
  logic [15:0] held_rgb_next;
  logic [9:0]  held_x_next;
  logic [9:0]  held_y_next;
  logic        held_first_next;
  logic [1:0]  emit_count;
  out_t        emit0;
  out_t        emit1;

  always_comb begin
    logic [15:0] rgb;
    logic        adjacent;
    out_t        held_out;

    rgb = s1_index_ok ? {pal_q[7:0], pal_q[15:8]} : 16'd0;
    adjacent = held_valid && (held_y == s1_y)
               && (({1'b0, held_x} + 11'd1) == {1'b0, s1_x});

    held_valid_next = held_valid;
    held_rgb_next   = held_rgb;
    held_x_next     = held_x;
    held_y_next     = held_y;
    held_first_next = held_first;
    emit_count      = 2'd0;
    emit0           = '0;
    emit1           = '0;

    held_out = '{rgb: held_rgb, x: held_x, y: held_y, span_start: held_first,
                 span_end: 1'b1};

    if (s1_valid) begin
      if (s1_visible) begin
        if (s1_transparent) begin
          // A skipped pixel breaks the run.
          if (held_valid) begin
            emit0           = held_out;
            emit_count      = 2'd1;
            held_valid_next = 1'b0;
          end
        end else begin
          if (held_valid) begin
            emit0          = held_out;
            emit0.span_end = !adjacent;
            emit_count     = 2'd1;
          end
          held_valid_next = 1'b1;
          held_first_next = !adjacent;
          held_rgb_next   = rgb;
          held_x_next     = s1_x;
          held_y_next     = s1_y;
        end
      end
      // Line end flushes whatever is held, including the pixel just taken.
      if (s1_last && held_valid_next) begin
        if (emit_count == 2'd0) begin
          emit0 = '{rgb: held_rgb_next, x: held_x_next, y: held_y_next,
                    span_start: held_first_next, span_end: 1'b1};
        end else begin
          emit1 = '{rgb: held_rgb_next, x: held_x_next, y: held_y_next,
                    span_start: held_first_next, span_end: 1'b1};
        end
        emit_count      = emit_count + 2'd1;
        held_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_rgb   <= '0;
      held_x     <= '0;
      held_y     <= '0;
      held_first <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
      held_rgb   <= held_rgb_next;
      held_x     <= held_x_next;
      held_y     <= held_y_next;
      held_first <= held_first_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: takes up to two results per cycle, gives one when the output is not stalled.
  // ---------------------------------------------------------------------------
  out_t               outq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr;
  logic [OUTQ_AW-1:0] rd_ptr;
  logic [OUTQ_AW:0]   outq_count;
  logic               out_pop;
  out_t               out_head;

  assign out_valid = (outq_count != '0);
  assign out_pop   = out_valid && !out_stall;
  assign out_head  = outq[rd_ptr];

  assign pixel_rgb  = out_head.rgb;
  assign screen_x   = out_head.x;
  assign screen_y   = out_head.y;
  assign span_start = out_head.span_start;
  assign span_end   = out_head.span_end;

  // Room is reserved for two results from the pixel in flight and two from a new one.
  assign in_stall = ({1'b0, outq_count} + (s1_valid ? (OUTQ_AW+2)'(2) : '0)
                     + (OUTQ_AW+2)'(2)) > (OUTQ_AW+2)'(OUTQ_DEPTH);

  always_ff @(posedge clk) begin
    if (emit_count != 2'd0) begin
      outq[wr_ptr] <= emit0;
    end
    if (emit_count == 2'd2) begin
      outq[wr_ptr + OUTQ_AW'(1)] <= emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      outq_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + OUTQ_AW'(emit_count);
      rd_ptr     <= rd_ptr + OUTQ_AW'(out_pop);
      outq_count <= outq_count + (OUTQ_AW+1)'(emit_count) - (OUTQ_AW+1)'(out_pop);
    end
  end

endmodule
